FILE: rtl/core/clt_pkg.sv
package clt_pkg;

   // Field widths of the request and response channels.
   localparam int TYPE_W  = 2;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 4;
   localparam int POS_W   = 4;
   localparam int LEN_W   = 4;

   // Request kinds.
   localparam logic [TYPE_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SEARCH = 2'd2;

   // The reserved value is never stored and never found.
   localparam logic signed [VALUE_W-1:0] RESERVED_VALUE = -32'sd1;

endpackage

FILE: rtl/core/compacting_list_table_unit.sv
// Append, unused kinds, failed removes and reserved-value searches answer in the cycle
// after the request transfer; a remove first moves every entry above index i one slot down,
// and a search sweeps up from position 0 until it hits or runs past the last entry.
// Throughput: one request at a time; the sweeps walk the single read port one entry per cycle.
// Synchronous active-high reset empties the list and idles; entry contents are not cleared.
module compacting_list_table_unit #(
   parameter int SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [clt_pkg::TYPE_W-1:0]          req_type,
   input  logic signed [clt_pkg::VALUE_W-1:0]  req_value,
   input  logic [clt_pkg::INDEX_W-1:0]         req_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [clt_pkg::POS_W-1:0]           rsp_position,
   output logic [clt_pkg::LEN_W-1:0]           rsp_length
);
   import clt_pkg::*;

   // The list holds at most CAP values. The count needs CW bits, a memory address AW.
   localparam int CAP = SLOTS - 1;
   localparam int CW  = $clog2(SLOTS);
   localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int XW  = (CW > INDEX_W) ? CW : INDEX_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_SEARCH,
      S_RESP
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              ptr_ff, ptr_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [CW-1:0]              rd_idx_ff, rd_idx_in;
   logic signed [VALUE_W-1:0]  rd_data_ff;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [POS_W-1:0]           rsp_pos_ff, rsp_pos_in;

   // Entry storage: one write port and one registered read port.
   logic signed [VALUE_W-1:0]  mem [CAP];
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic signed [VALUE_W-1:0]  wr_data;
   logic [AW-1:0]              rd_addr;
   logic [CW-1:0]              wr_idx;

   // Sweep control: issue is shared by the remove and search passes, hit serves the search.
   logic                       issue;
   logic                       hit;

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = (state_ff == S_RESP);
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_length   = LEN_W'(count_ff);

   // A read is issued while the sweep pointer is still inside the list.
   assign issue  = (ptr_ff < count_ff);
   // The search comparator: the entry read last cycle against the held search value.
   assign hit    = rd_vld_ff && (rd_data_ff == value_ff);
   assign wr_idx = rd_idx_ff - 1'b1;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = rd_idx_ff;
      value_in   = value_ff;
      rsp_ok_in  = rsp_ok_ff;
      rsp_pos_in = rsp_pos_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = req_value;
      rd_addr    = ptr_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rsp_ok_in  = 1'b0;
               rsp_pos_in = '0;
               state_in   = S_RESP;
               unique case (req_type)
                  REQ_APPEND: begin
                     // Fullness is checked first; the reserved value succeeds unstored.
                     if (count_ff < CW'(CAP)) begin
                        rsp_ok_in = 1'b1;
                        if (req_value != RESERVED_VALUE) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  REQ_REMOVE: begin
                     // Entries above the removed one are read and written one slot down.
                     if (XW'(req_index) < XW'(count_ff)) begin
                        ptr_in   = CW'(req_index) + 1'b1;
                        state_in = S_SHIFT;
                     end
                  end
                  REQ_SEARCH: begin
                     // The reserved value is never found, so no sweep is started for it.
                     if (req_value != RESERVED_VALUE) begin
                        ptr_in   = '0;
                        value_in = req_value;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     // An unused request kind only reports the length.
                  end
               endcase
            end
         end
         S_SHIFT: begin
            rd_vld_in = issue;
            rd_idx_in = ptr_ff;
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_idx[AW-1:0];
               wr_data = rd_data_ff;
            end
            if (!issue && !rd_vld_ff) begin
               count_in  = count_ff - 1'b1;
               rsp_ok_in = 1'b1;
               state_in  = S_RESP;
            end
         end
         S_SEARCH: begin
            rd_vld_in = issue;
            rd_idx_in = ptr_ff;
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (hit) begin
               rsp_ok_in  = 1'b1;
               rsp_pos_in = POS_W'(rd_idx_ff);
               state_in   = S_RESP;
            end else if (!issue && !rd_vld_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
         rsp_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
         rsp_ok_ff <= rsp_ok_in;
      end
      ptr_ff     <= ptr_in;
      rd_idx_ff  <= rd_idx_in;
      value_ff   <= value_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // The request and response sides are never open at the same time.
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request and response handshakes both open");

   // The count never exceeds the list capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(CAP))
      else $error("list count beyond capacity");

   // The count moves by at most one per cycle.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == CW'($past(count_ff) + 1'b1)) ||
                        (count_ff == CW'($past(count_ff) - 1'b1)))
      else $error("list count jumped by more than one");

   // A search for the reserved value answers at once with a miss.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type == REQ_SEARCH) && (req_value == RESERVED_VALUE))
      |=> (rsp_valid && !rsp_ok && (rsp_position == '0)))
      else $error("reserved value search did not miss");

endmodule

FILE: tb/compacting_list_table_checker.sv
module compacting_list_table_checker #(
   parameter int SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [clt_pkg::TYPE_W-1:0]          req_type,
   input  logic signed [clt_pkg::VALUE_W-1:0]  req_value,
   input  logic [clt_pkg::INDEX_W-1:0]         req_index,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_ok,
   input  logic [clt_pkg::POS_W-1:0]           rsp_position,
   input  logic [clt_pkg::LEN_W-1:0]           rsp_length,
   output int                                  mismatch_count,
   output int                                  outstanding
);

   import clt_pkg::*;

   localparam int CAPACITY = SLOTS - 1;

   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] position;
      logic [LEN_W-1:0] length;
   } list_result_type;

   // Shadow copy of the list contents and its length.
   logic signed [VALUE_W-1:0] shadow_values [0:CAPACITY-1];
   int unsigned               shadow_len;

   list_result_type awaited_results [$];
   list_result_type oldest;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      shadow_len     = 0;
   end

   // Applies one request to the shadow list and returns the response it must produce.
   function automatic list_result_type apply_request(input logic [TYPE_W-1:0] kind,
                                                     input logic signed [VALUE_W-1:0] operand,
                                                     input logic [INDEX_W-1:0] slot);
      list_result_type res;
      bit              found;
      res   = '0;
      found = 1'b0;
      case (kind)
         REQ_APPEND: begin
            if (shadow_len < CAPACITY) begin
               if (operand != RESERVED_VALUE) begin
                  shadow_values[shadow_len] = operand;
                  shadow_len++;
               end
               res.ok = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (slot < shadow_len) begin
               for (int unsigned i = slot; i + 1 < shadow_len; i++)
                  shadow_values[i] = shadow_values[i + 1];
               shadow_len--;
               res.ok = 1'b1;
            end
         end
         REQ_SEARCH: begin
            if (operand != RESERVED_VALUE) begin
               for (int unsigned i = 0; i < shadow_len; i++) begin
                  if (!found && shadow_values[i] == operand) begin
                     found        = 1'b1;
                     res.ok       = 1'b1;
                     res.position = i[POS_W-1:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.length = shadow_len[LEN_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_len = 0;
         awaited_results.delete();
      end else begin
         // A response always belongs to a request accepted on an earlier edge,
         // so it is matched before this edge's request is predicted.
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_ok !== oldest.ok) begin
                  $error("field ok: expected %0d actual %0d", oldest.ok, rsp_ok);
                  mismatch_count++;
               end
               if (rsp_position !== oldest.position) begin
                  $error("field position: expected %0d actual %0d",
                         oldest.position, rsp_position);
                  mismatch_count++;
               end
               if (rsp_length !== oldest.length) begin
                  $error("field length: expected %0d actual %0d",
                         oldest.length, rsp_length);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(apply_request(req_type, req_value, req_index));
      end
      outstanding = awaited_results.size();
   end

endmodule

FILE: tb/tb_compacting_list_table_unit.sv
module tb_compacting_list_table_unit;

   import clt_pkg::*;

   // The request code that the block must ignore; it still yields a response.
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   localparam int SLOTS        = 16;
   localparam int RANDOM_ITEMS = 850;

   // After the last expected response, allow a full sweep plus margin for a
   // stray response to show up before the verdict.
   localparam int DRAIN_CYCLES = SLOTS + 8;

   // Between two transfers a correct run waits at most a sender gap, the
   // slowest request and a receiver stall. The limit leaves a wide margin
   // over that.
   localparam int WATCHDOG_LIMIT = 1000;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [TYPE_W-1:0]            req_type;
   logic signed [VALUE_W-1:0]    req_value;
   logic [INDEX_W-1:0]           req_index;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_ok;
   logic [POS_W-1:0]             rsp_position;
   logic [LEN_W-1:0]             rsp_length;

   int mismatch_count;
   int outstanding;

   // Burst modes switch idling off for stretches so that back-to-back
   // transfers are covered as well as random gaps.
   bit req_burst;
   bit rsp_burst;

   // The random part alternates between growing and shrinking the list so
   // that it repeatedly runs from empty to full and back.
   bit growing;

   int idle_cycles;

   compacting_list_table_unit #(
      .SLOTS(SLOTS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_value   (req_value),
      .req_index   (req_index),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_ok      (rsp_ok),
      .rsp_position(rsp_position),
      .rsp_length  (rsp_length)
   );

   compacting_list_table_checker #(
      .SLOTS(SLOTS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_value     (req_value),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_position  (rsp_position),
      .rsp_length    (rsp_length),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Drives one request at the falling edge after a random gap and holds it
   // until the transfer completes at a rising edge.
   task automatic issue_request(input logic [TYPE_W-1:0] kind,
                                input logic signed [VALUE_W-1:0] operand,
                                input logic [INDEX_W-1:0] slot);
      int gap;
      if ($urandom_range(0, 39) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_value <= operand;
      req_index <= slot;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Mostly small values, so that searches hit and duplicates occur, mixed
   // with the reserved value, the signed extremes and full-width noise.
   function automatic logic signed [VALUE_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return RESERVED_VALUE;
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $urandom_range(0, 11) - 6;
      endcase
   endfunction

   // Response side: a random stall before each response, then ready stays
   // high until the transfer happens.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      rsp_burst = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Watchdog: ends the run if no transfer happens on either channel for too
   // long. Reset cycles do not count toward the limit.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Request stimulus and the final verdict.
   initial begin
      int                        roll;
      logic [TYPE_W-1:0]         kind;
      logic [INDEX_W-1:0]        slot;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_type  = REQ_APPEND;
      req_value = '0;
      req_index = '0;
      req_burst = 1'b0;
      growing   = 1'b1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Searching and removing on an empty list must fail.
      issue_request(REQ_SEARCH, 32'sd5, 4'd0);
      issue_request(REQ_REMOVE, 32'sd0, 4'd0);
      // Signed extremes are stored; the reserved value reports success but
      // is not stored, and a search for it never matches.
      issue_request(REQ_APPEND, 32'sh7FFF_FFFF, 4'd0);
      issue_request(REQ_APPEND, 32'sh8000_0000, 4'd15);
      issue_request(REQ_APPEND, RESERVED_VALUE, 4'd0);
      issue_request(REQ_SEARCH, RESERVED_VALUE, 4'd0);
      issue_request(REQ_SEARCH, 32'sh8000_0000, 4'd0);
      // The unused request code must leave the list alone.
      issue_request(REQ_UNUSED, 32'sh5A5A_A5A5, 4'hF);
      // Fill the list with repeating values so that searches see duplicates.
      for (int n = 0; n < 13; n++)
         issue_request(REQ_APPEND, n % 4, n[INDEX_W-1:0]);
      // Appends to a full list fail, the reserved value included.
      issue_request(REQ_APPEND, 32'sd7, 4'd0);
      issue_request(REQ_APPEND, RESERVED_VALUE, 4'd0);
      // The first of several equal entries is reported.
      issue_request(REQ_SEARCH, 32'sd3, 4'd0);
      // An index equal to the count is out of range; then remove the last
      // entry and the first one, which shifts everything down.
      issue_request(REQ_REMOVE, 32'sd0, 4'd15);
      issue_request(REQ_REMOVE, 32'sd0, 4'd14);
      issue_request(REQ_REMOVE, 32'sd0, 4'd0);

      // Random part.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 39) == 0)
            growing = !growing;
         roll = $urandom_range(0, 99);
         if (roll < 3)
            kind = REQ_UNUSED;
         else if (roll < 28)
            kind = REQ_SEARCH;
         else
            kind = (($urandom_range(0, 3) != 0) == growing) ? REQ_APPEND : REQ_REMOVE;
         // Removes mostly aim at low positions so that most succeed; the rest
         // cover the whole index range, out-of-range ones included.
         if (kind == REQ_REMOVE && $urandom_range(0, 3) != 0)
            slot = INDEX_W'($urandom_range(0, 5));
         else
            slot = INDEX_W'($urandom_range(0, 15));
         issue_request(kind, pick_operand(), slot);
      end
      req_valid <= 1'b0;

      // Wait for every response, then a little longer for stray ones. The
      // watchdog bounds both waits.
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
